// ===== rtl/core/scpq_pkg.sv =====
// shared types, palette constants and dither table for the six-color pixel quantizer
package scpq_pkg;

    localparam int NumColors      = 6;
    localparam int NumChans       = 3;
    localparam int DitherStrength = 5;
    localparam int DitherBias     = 8;

    // channel and tolerance widths
    typedef logic [7:0] chan_t;
    typedef logic [6:0] tol_t;

    localparam tol_t TOL_MAX = 7'd64;

    // dense palette index
    typedef logic [2:0] pal_idx_t;

    localparam pal_idx_t PAL_BLACK  = 3'd0;
    localparam pal_idx_t PAL_WHITE  = 3'd1;
    localparam pal_idx_t PAL_YELLOW = 3'd2;
    localparam pal_idx_t PAL_RED    = 3'd3;
    localparam pal_idx_t PAL_BLUE   = 3'd4;
    localparam pal_idx_t PAL_GREEN  = 3'd5;

    // configuration register indexes
    typedef logic [1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_PASSTHROUGH = 2'd0;
    localparam cfg_addr_t CFG_DITHER      = 2'd1;
    localparam cfg_addr_t CFG_TOLERANCE   = 2'd2;

    // every palette channel is either 0 or 255: bit 2 red, bit 1 green, bit 0 blue
    localparam logic [2:0] PAL_BITS [NumColors] = '{
        3'b000,     // black
        3'b111,     // white
        3'b110,     // yellow
        3'b100,     // red
        3'b001,     // blue
        3'b010      // green
    };

    // 4x4 ordered dither matrix, [row][col]
    localparam int BAYER [4][4] = '{
        '{ 0,  8,  2, 10},
        '{12,  4, 14,  6},
        '{ 3, 11,  1,  9},
        '{15,  7, 13,  5}
    };

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef struct packed {
        logic passthrough;
        logic dither_en;
        tol_t tol;
    } cfg_t;

    typedef struct packed {
        logic     hit;
        pal_idx_t idx;
    } match_t;

    // signed channel offset for one dither position, range -40..35
    function automatic logic signed [6:0] dither_delta(input logic [1:0] row,
                                                        input logic [1:0] col);
        return 7'((BAYER[row][col] - DitherBias) * DitherStrength);
    endfunction

endpackage

// ===== rtl/core/scpq_dither.sv =====
// ordered dither offset with clamp to the byte range
module scpq_dither
    import scpq_pkg::*;
(
    input  pixel_t     pix_in,
    input  logic [1:0] row_phase,
    input  logic [1:0] col_phase,
    input  logic       enable,
    output pixel_t     pix_out
);

    logic signed [6:0] delta;
    logic signed [9:0] sum [NumChans];
    chan_t             chan_in [NumChans];
    chan_t             chan_out [NumChans];

    assign delta      = dither_delta(row_phase, col_phase);
    assign chan_in[0] = pix_in.red;
    assign chan_in[1] = pix_in.green;
    assign chan_in[2] = pix_in.blue;

    // add offset and saturate each channel; pass it unchanged when disabled
    always_comb begin
        for (int k = 0; k < NumChans; k++) begin
            sum[k] = $signed({2'b00, chan_in[k]}) + 10'(delta);
            if (!enable) begin
                chan_out[k] = chan_in[k];
            end else if (sum[k] < 10'sd0) begin
                chan_out[k] = 8'd0;
            end else if (sum[k] > 10'sd255) begin
                chan_out[k] = 8'd255;
            end else begin
                chan_out[k] = sum[k][7:0];
            end
        end
    end

    assign pix_out.red   = chan_out[0];
    assign pix_out.green = chan_out[1];
    assign pix_out.blue  = chan_out[2];

endmodule

// ===== rtl/core/scpq_match.sv =====
// first palette color within the per-channel tolerance
module scpq_match
    import scpq_pkg::*;
(
    input  pixel_t pix,
    input  tol_t   tol,
    output match_t match
);

    tol_t  tol_sat;
    chan_t chan [NumChans];
    logic  near_lo [NumChans];
    logic  near_hi [NumChans];
    logic  color_ok [NumColors];

    assign tol_sat = (tol > TOL_MAX) ? TOL_MAX : tol;
    assign chan[0] = pix.red;
    assign chan[1] = pix.green;
    assign chan[2] = pix.blue;

    // per channel: close to 0, or close to 255 (255 - c is ~c)
    always_comb begin
        for (int k = 0; k < NumChans; k++) begin
            near_lo[k] = chan[k] <= {1'b0, tol_sat};
            near_hi[k] = ~chan[k] <= {1'b0, tol_sat};
        end
    end

    // priority pick, lowest index wins
    always_comb begin
        match.hit = 1'b0;
        match.idx = PAL_BLACK;
        for (int i = NumColors - 1; i >= 0; i--) begin
            color_ok[i] = 1'b1;
            for (int k = 0; k < NumChans; k++) begin
                if (PAL_BITS[i][NumChans - 1 - k]) begin
                    color_ok[i] = color_ok[i] & near_hi[k];
                end else begin
                    color_ok[i] = color_ok[i] & near_lo[k];
                end
            end
            if (color_ok[i]) begin
                match.hit = 1'b1;
                match.idx = pal_idx_t'(i);
            end
        end
    end

endmodule

// ===== rtl/core/scpq_nearest.sv =====
// nearest palette color by squared distance
// with palette channels at 0 or 255, (255-c)^2 - c^2 = 255*(255-2c), so the
// squared distance less the black distance, divided by 255, is the sum of
// (255 - 2c) over the channels a color has at full scale; order and ties hold
module scpq_nearest
    import scpq_pkg::*;
(
    input  pixel_t   pix,
    output pal_idx_t idx
);

    chan_t              chan [NumChans];
    logic signed [10:0] weight [NumChans];
    logic signed [10:0] cost [NumColors];
    logic signed [10:0] best_cost;

    assign chan[0] = pix.red;
    assign chan[1] = pix.green;
    assign chan[2] = pix.blue;

    // per-channel weight and per-color relative cost
    always_comb begin
        for (int k = 0; k < NumChans; k++) begin
            weight[k] = 11'sd255 - $signed({2'b00, chan[k], 1'b0});
        end
        for (int i = 0; i < NumColors; i++) begin
            cost[i] = 11'sd0;
            for (int k = 0; k < NumChans; k++) begin
                if (PAL_BITS[i][NumChans - 1 - k]) begin
                    cost[i] = cost[i] + weight[k];
                end
            end
        end
    end

    // running minimum, strict compare keeps the earlier color on ties
    always_comb begin
        best_cost = cost[0];
        idx       = PAL_BLACK;
        for (int i = 1; i < NumColors; i++) begin
            if (cost[i] < best_cost) begin
                best_cost = cost[i];
                idx       = pal_idx_t'(i);
            end
        end
    end

endmodule

// ===== rtl/core/six_color_pixel_quantizer.sv =====
// six-color pixel quantizer: input register, single-pass select, output register
// path: an accepted word passes the input register, then the output register
// throughput: one word per clock while m_tready is high
// all six colors are scored side by side
// the input register still takes one word while an output word waits for m_tready
// reset (aresetn low, synchronous) empties both registers and clears the
// configuration to convert mode, dither off, tolerance zero
module six_color_pixel_quantizer
    import scpq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_addr_t   cfg_index,
    input  logic [6:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16],
                                   // col_phase[25:24], row_phase[27:26], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // palette_index[2:0], zero pad
    output logic        m_tuser    // tolerance_match[0]
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    pixel_t     pix_reg;
    logic [1:0] col_reg;
    logic [1:0] row_reg;
    logic       out_valid_reg;
    pal_idx_t   idx_reg;
    logic       hit_reg;

    logic       out_adv;
    pixel_t     pix_dith;
    match_t     match;
    pal_idx_t   near_idx;
    pal_idx_t   idx_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PASSTHROUGH: cfg_reg.passthrough <= cfg_data[0];
                CFG_DITHER:      cfg_reg.dither_en   <= cfg_data[0];
                CFG_TOLERANCE:   cfg_reg.tol         <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: each register moves when the one after it can take a word
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pix_reg.red   <= s_tdata[7:0];
            pix_reg.green <= s_tdata[15:8];
            pix_reg.blue  <= s_tdata[23:16];
            col_reg       <= s_tdata[25:24];
            row_reg       <= s_tdata[27:26];
        end
    end

    // dither applies in convert mode only
    scpq_dither u_dither (
        .pix_in    (pix_reg),
        .row_phase (row_reg),
        .col_phase (col_reg),
        .enable    (cfg_reg.dither_en && !cfg_reg.passthrough),
        .pix_out   (pix_dith)
    );

    // tolerance match on the undithered pixel
    scpq_match u_match (
        .pix   (pix_reg),
        .tol   (cfg_reg.tol),
        .match (match)
    );

    scpq_nearest u_nearest (
        .pix (pix_dith),
        .idx (near_idx)
    );

    // passthrough prefers the tolerance match
    assign idx_next = (cfg_reg.passthrough && match.hit) ? match.idx : near_idx;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            idx_reg <= idx_next;
            hit_reg <= match.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, idx_reg};
    assign m_tuser  = hit_reg;

endmodule

// ===== verif/six_color_pixel_quantizer_checker.sv =====
// result checker for the six-color pixel quantizer: shadow registers, color prediction, compare
module six_color_pixel_quantizer_checker
    import scpq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_addr_t   cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16],
                                   // col_phase[25:24], row_phase[27:26], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // palette_index[2:0], zero pad
    input  logic        m_tuser,   // tolerance_match[0]
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pal_idx_t color;
        logic     in_tol;
    } quant_t;

    // palette channels in index order: black, white, yellow, red, blue, green
    localparam int PALETTE [NumColors][NumChans] = '{
        '{  0,   0,   0},
        '{255, 255, 255},
        '{255, 255,   0},
        '{255,   0,   0},
        '{  0,   0, 255},
        '{  0, 255,   0}
    };

    // ordered dither thresholds, [row][col]
    localparam int ORDER_MAP [4][4] = '{
        '{ 0,  8,  2, 10},
        '{12,  4, 14,  6},
        '{ 3, 11,  1,  9},
        '{15,  7, 13,  5}
    };

    // shadow copy of the configuration registers
    logic   pass_mode;
    logic   dither_on;
    tol_t   tol_reg;

    quant_t expected_colors [$];

    // palette choice and tolerance flag for one input word
    function automatic quant_t quantize_pixel(input logic [31:0] word);
        int     pix [NumChans];
        int     tol;
        int     first_hit;
        int     best;
        int     min_err;
        int     sq_err;
        int     diff;
        int     delta;
        logic   all_close;
        quant_t q;
        pix[0] = int'(word[7:0]);
        pix[1] = int'(word[15:8]);
        pix[2] = int'(word[23:16]);
        tol = (int'(tol_reg) > int'(TOL_MAX)) ? int'(TOL_MAX) : int'(tol_reg);

        // tolerance search on the undithered pixel, first color wins
        first_hit = -1;
        for (int i = 0; i < NumColors; i++) begin
            all_close = 1'b1;
            for (int k = 0; k < NumChans; k++) begin
                diff = pix[k] - PALETTE[i][k];
                if (diff < 0) diff = -diff;
                if (diff > tol) all_close = 1'b0;
            end
            if (all_close && first_hit < 0) first_hit = i;
        end

        // ordered dither only applies in convert mode
        if (!pass_mode && dither_on) begin
            delta = (ORDER_MAP[word[27:26]][word[25:24]] - DitherBias) * DitherStrength;
            for (int k = 0; k < NumChans; k++) begin
                pix[k] = pix[k] + delta;
                if (pix[k] < 0) pix[k] = 0;
                if (pix[k] > 255) pix[k] = 255;
            end
        end

        // nearest color, earlier entry wins ties
        best    = 0;
        min_err = 32'h7fff_ffff;
        for (int i = 0; i < NumColors; i++) begin
            sq_err = 0;
            for (int k = 0; k < NumChans; k++) begin
                diff = pix[k] - PALETTE[i][k];
                sq_err += diff * diff;
            end
            if (sq_err < min_err) begin
                min_err = sq_err;
                best    = i;
            end
        end

        if (pass_mode && first_hit >= 0) best = first_hit;
        q.color  = pal_idx_t'(best);
        q.in_tol = (first_hit >= 0);
        return q;
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t ns] checker: %s", $time, msg);
        fail_count++;
    endtask

    // watch all three channels at the rising edge
    always @(posedge aclk) begin
        quant_t want;
        if (!aresetn) begin
            pass_mode = 1'b0;
            dither_on = 1'b0;
            tol_reg   = '0;
            expected_colors.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PASSTHROUGH: pass_mode = cfg_data[0];
                    CFG_DITHER:      dither_on = cfg_data[0];
                    CFG_TOLERANCE:   tol_reg   = cfg_data;
                    default: ;
                endcase
            end
            // result words against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    report_failure($sformatf("result word 0x%02h/%0b with nothing expected",
                                             m_tdata, m_tuser));
                end else begin
                    want = expected_colors.pop_front();
                    if (m_tdata[2:0] !== want.color)
                        report_failure($sformatf("palette_index expected %0d, got %0d",
                                                 want.color, m_tdata[2:0]));
                    if (m_tdata[7:3] !== 5'b0)
                        report_failure($sformatf("tdata pad expected 0, got 0x%02h",
                                                 m_tdata[7:3]));
                    if (m_tuser !== want.in_tol)
                        report_failure($sformatf("tolerance_match expected %0b, got %0b",
                                                 want.in_tol, m_tuser));
                end
            end
            // predict each accepted pixel
            if (s_tvalid && s_tready) expected_colors.push_back(quantize_pixel(s_tdata));
        end
        pending_count = expected_colors.size();
    end

endmodule

// ===== verif/six_color_pixel_quantizer_test.sv =====
// testbench top for the six-color pixel quantizer: clock, reset, pixel stimulus and verdict
module six_color_pixel_quantizer_test
    import scpq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        QuietLimit  = 2000;
    localparam int        RandPhases  = 8;
    localparam int        PhaseWords  = 100;
    localparam cfg_addr_t CFG_UNUSED  = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_addr_t   cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red[7:0], green[15:8], blue[23:16],
                            // col_phase[25:24], row_phase[27:26], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // palette_index[2:0], zero pad
    logic        m_tuser;   // tolerance_match[0]

    int fail_count;
    int pending_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int cur_tol;
    int pixels_sent;
    int directed_sent;
    int settings_run;
    int quiet_cycles;

    six_color_pixel_quantizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    six_color_pixel_quantizer_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("watchdog: no word moved for %0d cycles", QuietLimit);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [1:0] col,
                                               input logic [1:0] row);
        return {4'b0, row, col, b, g, r};
    endfunction

    // mostly near palette colors or near the gray ties, the rest uniform
    function automatic logic [31:0] random_pixel(input int tol);
        logic [7:0] ch [NumChans];
        logic [2:0] bits;
        int         span;
        int         off;
        int         kind;
        kind = $urandom_range(0, 9);
        bits = PAL_BITS[$urandom_range(0, NumColors - 1)];
        span = ((tol > 64) ? 64 : tol) + 4;
        for (int k = 0; k < NumChans; k++) begin
            off = $urandom_range(0, span);
            if (kind < 5) ch[k] = bits[2 - k] ? 8'(255 - off) : 8'(off);
            else if (kind < 7) ch[k] = 8'($urandom_range(118, 137));
            else ch[k] = 8'($urandom);
        end
        return pack_pixel(ch[0], ch[1], ch[2], 2'($urandom), 2'($urandom));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [31:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
    endtask

    task automatic write_reg(input cfg_addr_t idx, input logic [6:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // block idle: wait until all results are back and the pipeline has settled
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(input logic pass, input logic dither, input tol_t tol,
                              input logic [5:0] junk);
        wait_drained();
        write_reg(CFG_PASSTHROUGH, {junk, pass});
        write_reg(CFG_DITHER, {junk, dither});
        write_reg(CFG_TOLERANCE, tol);
        cfg_valid = 1'b0;
        cur_tol   = int'(tol);
        settings_run++;
    endtask

    initial begin
        tol_t tol_pick;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_PASSTHROUGH;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        tx_idle_pct   = 7;
        rx_idle_pct   = 86;
        cur_tol       = 0;
        pixels_sent   = 0;
        settings_run  = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // passthrough, zero tolerance: exact palette colors and a near miss
        set_config(1'b1, 1'b0, 7'd0, 6'd0);
        send_pixel(pack_pixel(8'd0,   8'd0,   8'd0,   2'd0, 2'd0));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 2'd1, 2'd1));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd0,   2'd2, 2'd2));
        send_pixel(pack_pixel(8'd255, 8'd0,   8'd0,   2'd3, 2'd3));
        send_pixel(pack_pixel(8'd0,   8'd0,   8'd255, 2'd0, 2'd3));
        send_pixel(pack_pixel(8'd0,   8'd255, 8'd0,   2'd3, 2'd0));
        send_pixel(pack_pixel(8'd1,   8'd0,   8'd0,   2'd1, 2'd2));

        // passthrough with dither set (ignored) and a tolerance that saturates
        set_config(1'b1, 1'b1, 7'd127, 6'd0);
        wait_drained();
        write_reg(CFG_UNUSED, 7'h55);
        cfg_valid = 1'b0;
        send_pixel(pack_pixel(8'd64,  8'd64,  8'd64,  2'd0, 2'd3));
        send_pixel(pack_pixel(8'd65,  8'd65,  8'd65,  2'd0, 2'd3));
        send_pixel(pack_pixel(8'd128, 8'd128, 8'd128, 2'd0, 2'd0));

        // convert with dither: offsets that pull both ends inward and a zero offset
        set_config(1'b0, 1'b1, 7'd64, 6'd0);
        send_pixel(pack_pixel(8'd0,   8'd0,   8'd0,   2'd0, 2'd3));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 2'd0, 2'd0));
        send_pixel(pack_pixel(8'd128, 8'd128, 8'd128, 2'd1, 2'd0));
        send_pixel(pack_pixel(8'd100, 8'd100, 8'd100, 2'd3, 2'd2));

        // convert without dither: distance ties and the flag without steering
        set_config(1'b0, 1'b0, 7'd5, 6'd0);
        send_pixel(pack_pixel(8'd127, 8'd127, 8'd127, 2'd2, 2'd1));
        send_pixel(pack_pixel(8'd128, 8'd128, 8'd128, 2'd2, 2'd1));
        send_pixel(pack_pixel(8'd255, 8'd0,   8'd255, 2'd1, 2'd3));
        send_pixel(pack_pixel(8'd3,   8'd250, 8'd4,   2'd3, 2'd1));
        directed_sent = pixels_sent;

        // random phases over mode, dither, tolerance and idling
        for (int ph = 0; ph < RandPhases; ph++) begin
            case (ph % 4)
                0: tol_pick = 7'd0;
                1: tol_pick = TOL_MAX;
                2: tol_pick = 7'd127;
                default: tol_pick = 7'($urandom_range(0, 127));
            endcase
            set_config(ph[0], ph[1], tol_pick, 6'($urandom));
            tx_idle_pct = (ph < 3) ? 7 : (ph < 6) ? 86 : 0;
            rx_idle_pct = (ph < 3) ? 86 : (ph < 6) ? 7 : 0;
            for (int n = 0; n < PhaseWords; n++) send_pixel(random_pixel(cur_tol));
            s_tvalid = 1'b0;
        end

        // drain and settle
        wait_drained();
        repeat (8) @(negedge aclk);

        $display("covered %0d pixels (%0d directed) over %0d register settings",
                 pixels_sent, directed_sent, settings_run);
        $display("mismatches %0d, results still outstanding %0d", fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
